### design/dips_pkg.sv
// types, constants and microcode table for the dual incremental pi speed unit
`default_nettype none

package dips_pkg;

	typedef struct packed {
		logic signed [15:0] target_right;
		logic signed [15:0] target_left;
		logic signed [15:0] measured_right;
		logic signed [15:0] measured_left;
	} in_item_t;

	typedef struct packed {
		logic [7:0]         drive_right;
		logic [7:0]         drive_left;
		logic signed [15:0] raw_right;
		logic signed [15:0] raw_left;
		logic               fallback_right;
		logic               fallback_left;
	} out_item_t;

	// datapath widths
	localparam int SPD_W     = 16;
	localparam int GAIN_W    = 16;
	localparam int DIFF_W    = SPD_W + 1;
	localparam int ERR_W     = 25;
	localparam int EDIFF_W   = ERR_W + 1;
	localparam int MUL_B_W   = GAIN_W + 1;
	localparam int PROD_W    = EDIFF_W + MUL_B_W;
	localparam int ACC_W     = PROD_W + 1;
	localparam int ERR_SHIFT = 8;
	localparam int SUM_SHIFT = 13;
	localparam int Q_W       = ACC_W - SUM_SHIFT;

	// drive and feedforward constants
	localparam logic signed [15:0] DRIVE_LIMIT    = 16'sd255;
	localparam logic signed [15:0] FF_SAT_TARGET  = 16'sd10602;
	localparam logic [11:0]        FF_RECIP       = 12'd2979;
	localparam int                 FF_RECIP_SHIFT = 15;
	localparam logic [7:0]         DRIVE_MAX      = 8'd255;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_SCALE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KP_RIGHT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KIT_RIGHT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KP_LEFT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KIT_LEFT    = 3'd4;

	localparam logic [GAIN_W-1:0] RST_ERROR_SCALE = 16'd2444;
	localparam logic [GAIN_W-1:0] RST_KP          = 16'd256;
	localparam logic [GAIN_W-1:0] RST_KIT         = 16'd3;

	// sequencer
	localparam int PC_W = 3;
	localparam logic [PC_W-1:0] PC_START = 3'd0;
	localparam logic [PC_W-1:0] PC_EMIT  = 3'd6;

	typedef enum logic [1:0] {A_DIFF, A_EDIFF, A_ERR} a_sel_t;
	typedef enum logic [1:0] {B_SCALE, B_KP, B_KIT} b_sel_t;
	typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;
	typedef enum logic [1:0] {JMP_NEXT, JMP_SIDE, JMP_DONE} jmp_t;

	typedef struct packed {
		logic    mul_en;
		a_sel_t  a_sel;
		b_sel_t  b_sel;
		acc_op_t acc_op;
		logic    err_wr;
		logic    fin;
		logic    emit;
		jmp_t    jmp;
	} ucw_t;

	// one pass per side (steps 0..5), then the emit step
	function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
		ucw_t w;
		w = '{mul_en: 1'b0, a_sel: A_DIFF, b_sel: B_SCALE, acc_op: ACC_HOLD,
			err_wr: 1'b0, fin: 1'b0, emit: 1'b0, jmp: JMP_NEXT};
		unique case (pc)
			3'd0: begin
				w.mul_en = 1'b1;
				w.a_sel  = A_DIFF;
				w.b_sel  = B_SCALE;
				w.acc_op = ACC_LOAD;
			end
			3'd1: begin
				w.err_wr = 1'b1;
			end
			3'd2: begin
				w.mul_en = 1'b1;
				w.a_sel  = A_EDIFF;
				w.b_sel  = B_KP;
			end
			3'd3: begin
				w.mul_en = 1'b1;
				w.a_sel  = A_ERR;
				w.b_sel  = B_KIT;
				w.acc_op = ACC_ADD;
			end
			3'd4: begin
				w.acc_op = ACC_ADD;
			end
			3'd5: begin
				w.fin = 1'b1;
				w.jmp = JMP_SIDE;
			end
			3'd6: begin
				w.emit = 1'b1;
				w.jmp  = JMP_DONE;
			end
			default: begin
				w.jmp = JMP_DONE;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

### design/dips_chan_if.sv
// valid/ready channel carrying one payload item
`default_nettype none

interface dips_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/dual_incremental_pi_speed_unit.sv
// dual velocity-form pi speed controller: top level
//
// usage
// - sample (sink) takes one request per control tick: setpoint and measured speed for the
//   right and left motor. result (source) returns one item per request: drive bytes, saturated
//   pi outputs and feedforward fallback flags for both sides.
// - gains and error scale sit behind the apb port (index 0..4 at byte address 4*index);
//   write them only while no request is in flight.
// - a microcoded sequencer runs a six-step program once per side through one shared 26x17
//   multiplier, then an emit step loads the result register. one request is worked on at a
//   time, so a new one is taken only once the emit step of the last has passed.
// - the result register holds a finished item while the receiver stalls; a new request is
//   accepted and worked on meanwhile, and only its emit step waits for the register to free.
// - reset (arst_n low) loads the register defaults, clears the kept error and output of both
//   sides and empties the result register.
`default_nettype none

module dual_incremental_pi_speed_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	dips_chan_if.sink        sample,
	dips_chan_if.source      result
);
	import dips_pkg::*;

	// configuration
	logic [GAIN_W-1:0] error_scale_q, kp_right_q, kit_right_q, kp_left_q, kit_left_q;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic cfg_we;

	// sequencer
	logic busy_q, busy_d;
	logic side_q, side_d;
	logic [PC_W-1:0] pc_q, pc_d;
	ucw_t cw;
	logic advance;
	logic accept;

	// datapath
	in_item_t in_q;
	logic signed [SPD_W-1:0]   tgt, meas;
	logic signed [DIFF_W-1:0]  diff;
	logic [GAIN_W-1:0]         kp_sel, kit_sel, b_val;
	logic signed [ERR_W-1:0]   err_q, last_err_sel, err_d;
	logic signed [ERR_W-1:0]   last_err_right_q, last_err_left_q;
	logic signed [15:0]        last_out_right_q, last_out_left_q, last_out_sel;
	logic signed [EDIFF_W-1:0] ediff, mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_d, prod_q;
	logic [PROD_W-1:0]         err_bias, err_sum;
	logic signed [ACC_W-1:0]   acc_q;
	logic [ACC_W-1:0]          sum_bias, sum_rnd;
	logic signed [Q_W-1:0]     q_val;
	logic                      q_over, q_under;
	logic signed [15:0]        out_sat, out_neg;
	logic                      use_ff;
	logic [7:0]                mag, ff_drive, drive;
	logic [17:0]               ff_x;
	logic [11:0]               ff_y;
	logic [23:0]               ff_p;
	out_item_t                 hold_q, out_q;
	logic                      out_valid_q;

	// apb port
	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_we  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_scale_q <= RST_ERROR_SCALE;
			kp_right_q    <= RST_KP;
			kit_right_q   <= RST_KIT;
			kp_left_q     <= RST_KP;
			kit_left_q    <= RST_KIT;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ERROR_SCALE: error_scale_q <= pwdata[GAIN_W-1:0];
				REG_KP_RIGHT:    kp_right_q    <= pwdata[GAIN_W-1:0];
				REG_KIT_RIGHT:   kit_right_q   <= pwdata[GAIN_W-1:0];
				REG_KP_LEFT:     kp_left_q     <= pwdata[GAIN_W-1:0];
				REG_KIT_LEFT:    kit_left_q    <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_ERROR_SCALE: prdata = {16'd0, error_scale_q};
			REG_KP_RIGHT:    prdata = {16'd0, kp_right_q};
			REG_KIT_RIGHT:   prdata = {16'd0, kit_right_q};
			REG_KP_LEFT:     prdata = {16'd0, kp_left_q};
			REG_KIT_LEFT:    prdata = {16'd0, kit_left_q};
			default:         prdata = 32'd0;
		endcase
	end

	// sequencer
	assign cw           = ucode(pc_q);
	assign sample.ready = !busy_q;
	assign accept       = sample.valid && !busy_q;
	// only the emit step can stall, on a full result register that the receiver is not taking
	assign advance      = busy_q && !(cw.emit && out_valid_q && !result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			side_q <= 1'b0;
			pc_q   <= PC_START;
		end else begin
			busy_q <= busy_d;
			side_q <= side_d;
			pc_q   <= pc_d;
		end
	end

	always_comb begin
		busy_d = busy_q;
		side_d = side_q;
		pc_d   = pc_q;
		if (accept) begin
			busy_d = 1'b1;
			side_d = 1'b0;
			pc_d   = PC_START;
		end else if (advance) begin
			unique case (cw.jmp)
				JMP_NEXT: pc_d = pc_q + 1'b1;
				JMP_SIDE: begin
					if (!side_q) begin
						side_d = 1'b1;
						pc_d   = PC_START;
					end else begin
						pc_d = pc_q + 1'b1;
					end
				end
				JMP_DONE: begin
					busy_d = 1'b0;
					side_d = 1'b0;
					pc_d   = PC_START;
				end
				default: pc_d = PC_START;
			endcase
		end
	end

	// operand selection
	assign tgt          = side_q ? in_q.target_left : in_q.target_right;
	assign meas         = side_q ? in_q.measured_left : in_q.measured_right;
	assign diff         = {tgt[SPD_W-1], tgt} - {meas[SPD_W-1], meas};
	assign kp_sel       = side_q ? kp_left_q : kp_right_q;
	assign kit_sel      = side_q ? kit_left_q : kit_right_q;
	assign last_err_sel = side_q ? last_err_left_q : last_err_right_q;
	assign last_out_sel = side_q ? last_out_left_q : last_out_right_q;
	assign ediff        = {err_q[ERR_W-1], err_q} - {last_err_sel[ERR_W-1], last_err_sel};

	always_comb begin
		case (cw.a_sel)
			A_DIFF:  mul_a = {{(EDIFF_W-DIFF_W){diff[DIFF_W-1]}}, diff};
			A_EDIFF: mul_a = ediff;
			default: mul_a = {err_q[ERR_W-1], err_q};
		endcase
		case (cw.b_sel)
			B_SCALE: b_val = error_scale_q;
			B_KP:    b_val = kp_sel;
			default: b_val = kit_sel;
		endcase
	end

	assign mul_b  = {1'b0, b_val};
	assign prod_d = mul_a * mul_b;

	// error = product / 256, truncated toward zero
	assign err_bias = {{(PROD_W-ERR_SHIFT){1'b0}}, {ERR_SHIFT{prod_q[PROD_W-1]}}};
	assign err_sum  = prod_q + err_bias;
	assign err_d    = err_sum[ERR_SHIFT +: ERR_W];

	// pi sum / 2^13, truncated toward zero, then saturated to int16
	assign sum_bias = {{(ACC_W-SUM_SHIFT){1'b0}}, {SUM_SHIFT{acc_q[ACC_W-1]}}};
	assign sum_rnd  = acc_q + sum_bias;
	assign q_val    = sum_rnd[ACC_W-1:SUM_SHIFT];
	assign q_over   = !q_val[Q_W-1] && (|q_val[Q_W-2:15]);
	assign q_under  = q_val[Q_W-1] && !(&q_val[Q_W-2:15]);

	always_comb begin
		if (q_over) begin
			out_sat = 16'sh7FFF;
		end else if (q_under) begin
			out_sat = -16'sh8000;
		end else begin
			out_sat = q_val[15:0];
		end
	end

	assign use_ff  = (out_sat >= DRIVE_LIMIT) || (out_sat <= -DRIVE_LIMIT);
	assign out_neg = -out_sat;
	assign mag     = out_sat[15] ? out_neg[7:0] : out_sat[7:0];

	// feedforward 255*t/10560 = floor(floor(17*t/64)/11), the /11 by reciprocal
	assign ff_x = ({3'd0, tgt[14:0]} << 4) + {3'd0, tgt[14:0]};
	assign ff_y = ff_x[17:6];
	assign ff_p = 24'(ff_y) * 24'(FF_RECIP);

	always_comb begin
		if (tgt[SPD_W-1]) begin
			ff_drive = 8'd0;
		end else if (tgt >= FF_SAT_TARGET) begin
			ff_drive = DRIVE_MAX;
		end else begin
			ff_drive = ff_p[FF_RECIP_SHIFT +: 8];
		end
	end

	assign drive = use_ff ? ff_drive : mag;

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= sample.data;
		end
		if (busy_q && cw.mul_en) begin
			prod_q <= prod_d;
		end
		if (busy_q && cw.err_wr) begin
			err_q <= err_d;
		end
		if (busy_q) begin
			case (cw.acc_op)
				ACC_LOAD: acc_q <= {{(ACC_W-16-SUM_SHIFT){last_out_sel[15]}}, last_out_sel,
					{SUM_SHIFT{1'b0}}};
				ACC_ADD:  acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
				default:  acc_q <= acc_q;
			endcase
		end
		if (busy_q && cw.fin) begin
			if (side_q) begin
				hold_q.drive_left    <= drive;
				hold_q.raw_left      <= out_sat;
				hold_q.fallback_left <= use_ff;
			end else begin
				hold_q.drive_right    <= drive;
				hold_q.raw_right      <= out_sat;
				hold_q.fallback_right <= use_ff;
			end
		end
		if (advance && cw.emit) begin
			out_q <= hold_q;
		end
	end

	// per-side controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_right_q <= '0;
			last_err_left_q  <= '0;
			last_out_right_q <= '0;
			last_out_left_q  <= '0;
		end else if (busy_q && cw.fin) begin
			if (side_q) begin
				last_err_left_q <= err_q;
				last_out_left_q <= out_sat;
			end else begin
				last_err_right_q <= err_q;
				last_out_right_q <= out_sat;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && cw.emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// checks
	a_idle_side: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (side_q == 1'b0) && (pc_q == PC_START))
		else $error("sequencer idle with side or step not cleared");

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> busy_q && !side_q && (pc_q == PC_START))
		else $error("accepted request did not start the program");

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pc_q <= PC_EMIT)
		else $error("step counter beyond program end");

	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(busy_q && pc_q == PC_EMIT && side_q))
		else $error("result raised outside the emit step");

endmodule

`default_nettype wire

### verif/testbench.sv
// self-checking testbench for the dual incremental pi speed unit
`default_nettype none

module testbench;
	import dips_pkg::*;

	localparam int     HOLD_CYCLES  = 400;
	localparam int     SETTLE       = 20;
	localparam int     CYCLE_LIMIT  = 400000;
	localparam longint FF_NUM       = 255;
	localparam longint FF_DEN       = 330 * 32;
	localparam longint OUT_MAX      = 32767;
	localparam longint OUT_MIN      = -32768;
	localparam longint FB_EDGE      = 255;

	// tracks the kept error and output of both sides and the drive items still owed
	class drive_tracker;
		bit [15:0]   error_scale;
		bit [15:0]   kp [2];
		bit [15:0]   kit [2];
		longint      err_keep [2];
		longint      out_keep [2];
		out_item_t   due_outputs [$];
		int unsigned mismatches;

		function new();
			error_scale = RST_ERROR_SCALE;
			kp[0]       = RST_KP;
			kp[1]       = RST_KP;
			kit[0]      = RST_KIT;
			kit[1]      = RST_KIT;
			err_keep    = '{0, 0};
			out_keep    = '{0, 0};
			mismatches  = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
			case (idx)
				REG_ERROR_SCALE: error_scale = value;
				REG_KP_RIGHT:    kp[0] = value;
				REG_KIT_RIGHT:   kit[0] = value;
				REG_KP_LEFT:     kp[1] = value;
				REG_KIT_LEFT:    kit[1] = value;
				default: begin
				end
			endcase
		endfunction

		// one velocity-form pi step of one side (0 right, 1 left)
		function void pi_tick(int side, logic signed [15:0] tgt, logic signed [15:0] meas,
			output logic [7:0] drive, output logic signed [15:0] raw, output logic fb);
			longint diff;
			longint err;
			longint acc;
			longint q;
			longint ff;
			diff = longint'(tgt) - longint'(meas);
			err  = (diff * longint'(error_scale)) / (longint'(1) << ERR_SHIFT);
			acc  = out_keep[side] * (longint'(1) << SUM_SHIFT)
				+ longint'(kp[side]) * (err - err_keep[side])
				+ longint'(kit[side]) * err;
			q = acc / (longint'(1) << SUM_SHIFT);
			if (q > OUT_MAX) begin
				q = OUT_MAX;
			end else if (q < OUT_MIN) begin
				q = OUT_MIN;
			end
			err_keep[side] = err;
			out_keep[side] = q;
			if (q >= FB_EDGE || q <= -FB_EDGE) begin
				ff = (FF_NUM * longint'(tgt)) / FF_DEN;
				if (ff < 0) begin
					ff = 0;
				end else if (ff > 255) begin
					ff = 255;
				end
				drive = ff[7:0];
				fb    = 1'b1;
			end else begin
				drive = (q < 0) ? 8'(-q) : 8'(q);
				fb    = 1'b0;
			end
			raw = q[15:0];
		endfunction

		function void note_sample(in_item_t it);
			out_item_t o;
			pi_tick(0, it.target_right, it.measured_right, o.drive_right, o.raw_right,
				o.fallback_right);
			pi_tick(1, it.target_left, it.measured_left, o.drive_left, o.raw_left,
				o.fallback_left);
			due_outputs.push_back(o);
		endfunction

		function void flag(string what, out_item_t want, out_item_t got);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%s: want drv %0d/%0d raw %0d/%0d fb %0d/%0d, got drv %0d/%0d raw %0d/%0d fb %0d/%0d",
					what, want.drive_right, want.drive_left, want.raw_right, want.raw_left,
					want.fallback_right, want.fallback_left, got.drive_right, got.drive_left,
					got.raw_right, got.raw_left, got.fallback_right, got.fallback_left);
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (due_outputs.size() == 0) begin
				flag("unexpected result", '0, got);
				return;
			end
			want = due_outputs.pop_front();
			if (got.drive_right !== want.drive_right || got.drive_left !== want.drive_left ||
				got.raw_right !== want.raw_right || got.raw_left !== want.raw_left ||
				got.fallback_right !== want.fallback_right ||
				got.fallback_left !== want.fallback_left) begin
				flag("result mismatch", want, got);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	dips_chan_if #(.payload_t(in_item_t))  sample_if ();
	dips_chan_if #(.payload_t(out_item_t)) result_if ();

	drive_tracker tracker;
	bit           calm;
	bit           hold_off_pending;
	int unsigned  cycles;

	dual_incremental_pi_speed_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.sample  (sample_if),
		.result  (result_if)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic bit idle_draw();
		return !calm && ($urandom_range(0, 99) < 27);
	endfunction

	// receiver: random stalls plus one long hold-off on request
	initial begin
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				result_if.ready  = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			result_if.ready = !idle_draw();
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) begin
			tracker.check_result(result_if.data);
		end
	end

	function automatic in_item_t mk_item(int tr, int tl, int mr, int ml);
		in_item_t it;
		it.target_right   = 16'(tr);
		it.target_left    = 16'(tl);
		it.measured_right = 16'(mr);
		it.measured_left  = 16'(ml);
		return it;
	endfunction

	// mostly plausible setpoints with measured speed close by, the rest raw noise
	function automatic in_item_t rand_item();
		in_item_t it;
		int       tr;
		int       tl;
		if ($urandom_range(0, 9) < 4) begin
			it = in_item_t'({$urandom, $urandom});
		end else begin
			tr = int'($urandom_range(0, 24000)) - 12000;
			tl = int'($urandom_range(0, 24000)) - 12000;
			it = mk_item(tr, tl, tr + int'($urandom_range(0, 600)) - 300,
				tl + int'($urandom_range(0, 600)) - 300);
		end
		return it;
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_sample(in_item_t it);
		while (idle_draw()) begin
			sample_if.valid = 1'b0;
			@(negedge clk);
		end
		sample_if.valid = 1'b1;
		sample_if.data  = it;
		do @(posedge clk); while (!sample_if.ready);
		tracker.note_sample(it);
		@(negedge clk);
	endtask

	task automatic apb_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = {16'($urandom), value};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		tracker.write_reg(idx, value);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic drain();
		sample_if.valid = 1'b0;
		while (tracker.due_outputs.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic load_gains(logic [15:0] scale, logic [15:0] kpr, logic [15:0] kitr,
		logic [15:0] kpl, logic [15:0] kitl);
		drain();
		apb_write(REG_ERROR_SCALE, scale);
		apb_write(REG_KP_RIGHT, kpr);
		apb_write(REG_KIT_RIGHT, kitr);
		apb_write(REG_KP_LEFT, kpl);
		apb_write(REG_KIT_LEFT, kitl);
	endtask

	task automatic run_random(int n);
		repeat (n) send_sample(rand_item());
	endtask

	initial begin
		tracker          = new();
		calm             = 1'b0;
		hold_off_pending = 1'b0;
		cycles           = 0;
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		sample_if.valid  = 1'b0;
		sample_if.data   = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset gains, field extremes
		send_sample(mk_item(0, 0, 0, 0));
		send_sample(mk_item(32767, -32768, -32768, 32767));
		send_sample(mk_item(-32768, 32767, 32767, -32768));
		send_sample(mk_item(32767, -32768, -32768, 32767));
		send_sample(mk_item(-1, 1, 0, 0));

		// unity loop: raw output follows the speed difference
		load_gains(16'd256, 16'd8192, 16'd0, 16'd8192, 16'd0);
		// writes past the last register must change nothing
		apb_write(3'd5, 16'($urandom));
		apb_write(3'd6, 16'($urandom));
		apb_write(3'd7, 16'($urandom));
		send_sample(mk_item(1000, -1000, 746, -746));
		send_sample(mk_item(10602, -500, 10347, -245));
		send_sample(mk_item(10560, 10559, 10305, 10304));
		send_sample(mk_item(0, 0, -255, 255));
		send_sample(mk_item(32767, -32768, -32768, 32767));
		send_sample(mk_item(32767, -32768, -32768, 32767));
		send_sample(mk_item(0, 0, 0, 0));
		send_sample(mk_item(1, 1, 0, 0));
		send_sample(mk_item(300, 300, 300, 300));
		send_sample(mk_item(-32768, 32767, 32767, -32768));
		send_sample(mk_item(20000, 20000, 19746, 20254));

		load_gains(16'($urandom), 16'($urandom_range(0, 4096)), 16'($urandom_range(0, 512)),
			16'($urandom_range(0, 4096)), 16'($urandom_range(0, 512)));
		run_random(250);

		load_gains(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		run_random(150);

		// full gains while the receiver holds off so the unit backs up
		load_gains(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		hold_off_pending = 1'b1;
		run_random(200);

		load_gains(RST_ERROR_SCALE, 16'($urandom_range(0, 2048)), 16'($urandom_range(0, 255)),
			16'($urandom_range(0, 2048)), 16'($urandom_range(0, 255)));
		calm = 1'b1;
		run_random(300);
		calm = 1'b0;

		load_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		run_random(300);

		load_gains(16'd256, 16'd8192, 16'($urandom_range(0, 64)), 16'd8192,
			16'($urandom_range(0, 64)));
		run_random(300);

		drain();
		if (tracker.mismatches == 0 && tracker.due_outputs.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
